// ----- rtl/triangle_tangent_frame_unit_defines.svh -----
// Assertion macros for the tangent frame unit checker.
// Included by tfu_chk.sv; expects clk and arst_n in scope.
`ifndef TRIANGLE_TANGENT_FRAME_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_UNIT_DEFINES_SVH

// same-cycle implication
`define TFU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TFU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tfu_pkg.sv -----
// Package for the triangle tangent frame unit: widths, sequencer codes, state type.
// No dependencies.
`timescale 1ns / 1ps
package tfu_pkg;

	localparam int CW_DEF  = 32;
	localparam int NW_DEF  = 16;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ACC_W   = 70;
	localparam int MAG_W   = 68;
	localparam int TR_W    = 30;
	localparam int BR_W    = 20;
	localparam int SS_W    = 62;
	localparam int LEN_W   = 31;
	localparam int NUM_W   = 47;
	localparam int DEN_W   = 32;
	localparam int Q_W     = 17;
	localparam int TAN_W   = 16;
	localparam int FRAC_SH = 16;
	localparam int W_W     = 40;
	localparam int SPLIT   = 18;
	localparam int OP_W    = 5;

	localparam logic [OP_W-1:0] OP_TB_LAST  = 5'd11;
	localparam logic [OP_W-1:0] OP_SQ_FIRST = 5'd12;
	localparam logic [OP_W-1:0] OP_SQ_LAST  = 5'd14;
	localparam logic [OP_W-1:0] OP_CR_FIRST = 5'd15;
	localparam logic [OP_W-1:0] OP_CR_LAST  = 5'd20;
	localparam logic [OP_W-1:0] OP_DT_FIRST = 5'd21;
	localparam logic [OP_W-1:0] OP_DT_LAST  = 5'd26;

	localparam logic [1:0] LAST_CORNER = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_ABS,
		ST_RED,
		ST_SQGO,
		ST_SQWT,
		ST_DVGO,
		ST_DVWT,
		ST_EMIT
	} tfu_state_t;

endpackage

// ----- rtl/tfu_ifs.sv -----
// Stream interfaces of the tangent frame unit: vertex items in, tangent items out.
// No dependencies.
`timescale 1ns / 1ps
interface tfu_vtx_if;
	logic               valid;
	logic               ready;
	logic               mesh_start;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] tex_u;
	logic signed [31:0] tex_v;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	modport source(output valid, mesh_start, pos_x, pos_y, pos_z, tex_u, tex_v,
		norm_x, norm_y, norm_z, input ready);
	modport sink(input valid, mesh_start, pos_x, pos_y, pos_z, tex_u, tex_v,
		norm_x, norm_y, norm_z, output ready);
endinterface

interface tfu_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         corner;
	logic signed [15:0] tan_x;
	logic signed [15:0] tan_y;
	logic signed [15:0] tan_z;
	logic               handedness_negative;
	logic               last_of_triangle;
	modport source(output valid, corner, tan_x, tan_y, tan_z, handedness_negative,
		last_of_triangle, input ready);
	modport sink(input valid, corner, tan_x, tan_y, tan_z, handedness_negative,
		last_of_triangle, output ready);
endinterface

// ----- rtl/tfu_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on tfu_pkg.
`timescale 1ns / 1ps
module tfu_mul import tfu_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ----- rtl/tfu_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// Depends on tfu_pkg.
`timescale 1ns / 1ps
module tfu_sqrt import tfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SS_W-1:0]  x,
	output logic             done,
	output logic [LEN_W-1:0] root
);

	logic [SS_W-1:0] rem_q, r_q, bit_q, t;
	logic            busy_q, done_q;

	assign t    = r_q + bit_q;
	assign done = done_q;
	assign root = r_q[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= x;
			r_q   <= '0;
			bit_q <= SS_W'(1) << (SS_W - 2);
		end else if (busy_q) begin
			if (rem_q >= t) begin
				rem_q <= rem_q - t;
				r_q   <= (r_q >> 1) + bit_q;
			end else begin
				r_q   <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ----- rtl/tfu_div.sv -----
// Restoring divider, one quotient bit per cycle; quotient known to fit Q_W bits.
// Depends on tfu_pkg.
`timescale 1ns / 1ps
module tfu_div import tfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quo
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DEN_W-1:0] rem_q, den_q;
	logic [Q_W-1:0]   nb_q, q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   t;
	logic             ge;

	assign t    = {rem_q, nb_q[Q_W-1]};
	assign ge   = t >= {1'b0, den_q};
	assign done = done_q;
	assign quo  = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num[NUM_W-1:Q_W]);
			nb_q  <= num[Q_W-1:0];
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(t - {1'b0, den_q}) : t[DEN_W-1:0];
			nb_q  <= nb_q << 1;
			q_q   <= {q_q[Q_W-2:0], ge};
		end
	end

endmodule

// ----- rtl/triangle_tangent_frame_unit.sv -----
// Top level: triangle tangent frame unit, sequencer around one shared multiplier.
// Depends on tfu_pkg, tfu_ifs, tfu_mul, tfu_sqrt, tfu_div.
//
// channel  dir  handshake     payload
// vtx      in   valid/ready   mesh_start, pos_xyz, tex_uv, norm_xyz
// res      out  valid/ready   corner, tan_xyz, handedness_negative, last_of_triangle
// cfg      in   cfg_wr_en     cfg_wr_data (generation_enabled)
//
// Corners 0 and 1 are only held, without stalling. With generation enabled, a third
// vertex holds vtx.ready low for its 39 products on the shared multiplier, the
// 1-bit-per-cycle magnitude reduction, a square root and three divides; the divides
// are skipped when the tangent is zero.
// vtx.ready is low while a triangle is in work; a stalled res holds the sequencer.
// Reset is asynchronous; held vertex data has no reset.
`timescale 1ns / 1ps
module triangle_tangent_frame_unit import tfu_pkg::*; #(
	parameter int COORD_WIDTH  = CW_DEF,
	parameter int NORMAL_WIDTH = NW_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  logic     cfg_wr_data,
	tfu_vtx_if.sink  vtx,
	tfu_res_if.source res
);

	localparam int EW = COORD_WIDTH + 1;

	typedef enum logic [1:0] {AM_LOAD, AM_ADD, AM_SUB} acc_mode_t;
	typedef enum logic [2:0] {WB_NONE, WB_TW, WB_BW, WB_SS, WB_W, WB_D} wb_t;

	tfu_state_t state_q, state_d;
	logic [1:0] phase_q, ph;
	logic       gen_en_q;
	logic       res_v_q;
	logic [OP_W-1:0] op_q, opr;
	logic [1:0] corner_q, div_i_q;

	logic signed [COORD_WIDTH-1:0]  hp_q [2][3];
	logic signed [COORD_WIDTH-1:0]  ht_q [2][2];
	logic signed [NORMAL_WIDTH-1:0] hn_q [2][3];
	logic signed [NORMAL_WIDTH-1:0] v2n_q [3];
	logic signed [EW-1:0] e0_q [3];
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] du0_q, dv0_q, du1_q, dv1_q;
	logic signed [ACC_W-1:0] tw_q [3];
	logic signed [ACC_W-1:0] bw_q [3];
	logic [MAG_W-1:0] mt_q [3];
	logic [MAG_W-1:0] mb_q [3];
	logic [2:0] nt_q, nb_q;
	logic [SS_W-1:0] ss_q;
	logic [LEN_W-1:0] len_q;
	logic signed [TAN_W-1:0] tan_q [3];
	logic signed [W_W-1:0] w_q [3];
	logic d_neg_q;
	logic signed [ACC_W-1:0] acc_q, acc_nxt, p_ext;

	logic [1:0] res_corner_q;
	logic signed [TAN_W-1:0] res_tan_q [3];
	logic res_hand_q, res_last_q;

	logic signed [COORD_WIDTH-1:0] in_p [3];
	logic signed [COORD_WIDTH-1:0] in_t [2];
	logic signed [NORMAL_WIDTH-1:0] in_n [3];

	logic signed [MUL_W-1:0] op_a, op_b;
	logic signed [PROD_W-1:0] prod;
	acc_mode_t mode;
	logic sh18;
	wb_t wb;
	logic [1:0] wb_i;

	logic signed [BR_W:0] br [3];
	logic signed [NORMAL_WIDTH-1:0] nsel [3];
	logic tfit, bfit, take, emit_ld, sq_start, sq_done, dv_start, dv_done, len_zero;
	logic [LEN_W-1:0] sq_root;
	logic [Q_W-1:0] dv_q, qs;
	logic [NUM_W-1:0] dv_num;
	logic signed [TAN_W-1:0] tan_v;
	logic neg_eff;

	assign in_p = '{COORD_WIDTH'(vtx.pos_x), COORD_WIDTH'(vtx.pos_y), COORD_WIDTH'(vtx.pos_z)};
	assign in_t = '{COORD_WIDTH'(vtx.tex_u), COORD_WIDTH'(vtx.tex_v)};
	assign in_n = '{NORMAL_WIDTH'(vtx.norm_x), NORMAL_WIDTH'(vtx.norm_y),
		NORMAL_WIDTH'(vtx.norm_z)};

	assign vtx.ready = (state_q == ST_IDLE);
	assign take      = vtx.valid && vtx.ready;
	assign ph        = vtx.mesh_start ? 2'd0 : phase_q;
	assign emit_ld   = (state_q == ST_EMIT) && (!res_v_q || res.ready);
	assign len_zero  = (len_q == '0);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			br[i]   = nb_q[i] ? -$signed({1'b0, mb_q[i][BR_W-1:0]})
			                  : $signed({1'b0, mb_q[i][BR_W-1:0]});
			nsel[i] = (corner_q == 2'd0) ? hn_q[0][i] :
			          (corner_q == 2'd1) ? hn_q[1][i] : v2n_q[i];
		end
		tfit = 1'b1;
		bfit = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if ((mt_q[i] >> TR_W) != '0) tfit = 1'b0;
			if ((mb_q[i] >> BR_W) != '0) bfit = 1'b0;
		end
	end

	// product schedule
	always_comb begin
		op_a = '0;
		op_b = '0;
		mode = AM_ADD;
		sh18 = 1'b0;
		wb   = WB_NONE;
		wb_i = 2'd0;
		opr  = '0;
		if (op_q <= OP_TB_LAST) begin
			wb_i = op_q[3:2];
			case (op_q[1:0])
				2'd0: begin
					op_a = MUL_W'(e0_q[op_q[3:2]]); op_b = MUL_W'(dv1_q); mode = AM_LOAD;
				end
				2'd1: begin
					op_a = MUL_W'(e1_q[op_q[3:2]]); op_b = MUL_W'(dv0_q); mode = AM_SUB;
					wb = WB_TW;
				end
				2'd2: begin
					op_a = MUL_W'(e1_q[op_q[3:2]]); op_b = MUL_W'(du0_q); mode = AM_LOAD;
				end
				default: begin
					op_a = MUL_W'(e0_q[op_q[3:2]]); op_b = MUL_W'(du1_q); mode = AM_SUB;
					wb = WB_BW;
				end
			endcase
		end else if (op_q <= OP_SQ_LAST) begin
			opr  = op_q - OP_SQ_FIRST;
			op_a = $signed(MUL_W'(mt_q[opr[1:0]][TR_W-1:0]));
			op_b = op_a;
			mode = (opr[1:0] == 2'd0) ? AM_LOAD : AM_ADD;
			if (opr[1:0] == 2'd2) wb = WB_SS;
		end else if (op_q <= OP_CR_LAST) begin
			opr = op_q - OP_CR_FIRST;
			case (opr[2:0])
				3'd0: begin op_a = MUL_W'(tan_q[1]); op_b = MUL_W'(br[2]); mode = AM_LOAD; end
				3'd1: begin
					op_a = MUL_W'(tan_q[2]); op_b = MUL_W'(br[1]); mode = AM_SUB;
					wb = WB_W; wb_i = 2'd0;
				end
				3'd2: begin op_a = MUL_W'(tan_q[2]); op_b = MUL_W'(br[0]); mode = AM_LOAD; end
				3'd3: begin
					op_a = MUL_W'(tan_q[0]); op_b = MUL_W'(br[2]); mode = AM_SUB;
					wb = WB_W; wb_i = 2'd1;
				end
				3'd4: begin op_a = MUL_W'(tan_q[0]); op_b = MUL_W'(br[1]); mode = AM_LOAD; end
				default: begin
					op_a = MUL_W'(tan_q[1]); op_b = MUL_W'(br[0]); mode = AM_SUB;
					wb = WB_W; wb_i = 2'd2;
				end
			endcase
		end else begin
			opr  = op_q - OP_DT_FIRST;
			op_a = MUL_W'(nsel[opr[2:1]]);
			if (!opr[0]) begin
				op_b = MUL_W'(w_q[opr[2:1]] >>> SPLIT);
				sh18 = 1'b1;
				mode = (opr[2:1] == 2'd0) ? AM_LOAD : AM_ADD;
			end else begin
				op_b = $signed(MUL_W'(w_q[opr[2:1]][SPLIT-1:0]));
				if (opr[2:0] == 3'd5) wb = WB_D;
			end
		end
	end

	tfu_mul u_mul (.clk(clk), .a(op_a), .b(op_b), .p(prod));

	always_comb begin
		p_ext = sh18 ? (ACC_W'(prod) <<< SPLIT) : ACC_W'(prod);
		unique case (mode)
			AM_LOAD: acc_nxt = p_ext;
			AM_SUB:  acc_nxt = acc_q - p_ext;
			default: acc_nxt = acc_q + p_ext;
		endcase
	end

	assign dv_num = NUM_W'({mt_q[div_i_q][TR_W-1:0], {FRAC_SH{1'b0}}}) + NUM_W'(len_q);

	tfu_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start), .x(ss_q),
		.done(sq_done), .root(sq_root));

	tfu_div u_div (.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num),
		.den({len_q, 1'b0}), .done(dv_done), .quo(dv_q));

	always_comb begin
		neg_eff = nt_q[div_i_q] && (mt_q[div_i_q][TR_W-1:0] != '0);
		if (neg_eff) begin
			qs    = (dv_q > Q_W'(32768)) ? Q_W'(32768) : dv_q;
			tan_v = TAN_W'(-$signed({1'b0, qs}));
		end else begin
			qs    = (dv_q > Q_W'(32767)) ? Q_W'(32767) : dv_q;
			tan_v = TAN_W'(qs);
		end
	end

	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		dv_start = 1'b0;
		unique case (state_q)
			ST_IDLE: if (take && ph == 2'd2 && gen_en_q) state_d = ST_MUL;
			ST_MUL:  state_d = ST_ACC;
			ST_ACC: begin
				if (op_q == OP_TB_LAST) state_d = ST_ABS;
				else if (op_q == OP_SQ_LAST) state_d = ST_SQGO;
				else if (op_q == OP_DT_LAST) state_d = ST_EMIT;
				else state_d = ST_MUL;
			end
			ST_ABS:  state_d = ST_RED;
			ST_RED:  if (tfit && bfit) state_d = ST_MUL;
			ST_SQGO: begin sq_start = 1'b1; state_d = ST_SQWT; end
			ST_SQWT: if (sq_done) state_d = ST_DVGO;
			ST_DVGO: begin
				if (len_zero) begin
					if (div_i_q == 2'd2) state_d = ST_MUL;
				end else begin
					dv_start = 1'b1;
					state_d  = ST_DVWT;
				end
			end
			ST_DVWT: if (dv_done) state_d = (div_i_q == 2'd2) ? ST_MUL : ST_DVGO;
			ST_EMIT: if (emit_ld) state_d = (corner_q == LAST_CORNER) ? ST_IDLE : ST_MUL;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= 2'd0;
			gen_en_q <= 1'b1;
			res_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) gen_en_q <= cfg_wr_data;
			if (take) phase_q <= (ph == 2'd2) ? 2'd0 : ph + 2'd1;
			if (emit_ld) res_v_q <= 1'b1;
			else if (res.ready) res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (ph != 2'd2) begin
				hp_q[ph[0]] <= in_p;
				ht_q[ph[0]] <= in_t;
				hn_q[ph[0]] <= in_n;
			end else begin
				v2n_q <= in_n;
				for (int i = 0; i < 3; i++) begin
					e0_q[i] <= EW'(hp_q[1][i]) - EW'(hp_q[0][i]);
					e1_q[i] <= EW'(in_p[i]) - EW'(hp_q[0][i]);
				end
				du0_q <= EW'(ht_q[1][0]) - EW'(ht_q[0][0]);
				dv0_q <= EW'(ht_q[1][1]) - EW'(ht_q[0][1]);
				du1_q <= EW'(in_t[0]) - EW'(ht_q[0][0]);
				dv1_q <= EW'(in_t[1]) - EW'(ht_q[0][1]);
			end
			op_q     <= '0;
			corner_q <= 2'd0;
		end
		if (state_q == ST_ACC) begin
			acc_q <= acc_nxt;
			op_q  <= op_q + 1'b1;
			unique case (wb)
				WB_TW:   tw_q[wb_i] <= acc_nxt;
				WB_BW:   bw_q[wb_i] <= acc_nxt;
				WB_SS:   ss_q <= acc_nxt[SS_W-1:0];
				WB_W:    w_q[wb_i] <= W_W'(acc_nxt);
				WB_D:    d_neg_q <= acc_nxt[ACC_W-1];
				default: ;
			endcase
		end
		if (state_q == ST_ABS) begin
			for (int i = 0; i < 3; i++) begin
				nt_q[i] <= tw_q[i][ACC_W-1];
				nb_q[i] <= bw_q[i][ACC_W-1];
				mt_q[i] <= MAG_W'(tw_q[i][ACC_W-1] ? -tw_q[i] : tw_q[i]);
				mb_q[i] <= MAG_W'(bw_q[i][ACC_W-1] ? -bw_q[i] : bw_q[i]);
			end
		end
		if (state_q == ST_RED) begin
			for (int i = 0; i < 3; i++) begin
				if (!tfit) mt_q[i] <= mt_q[i] >> 1;
				if (!bfit) mb_q[i] <= mb_q[i] >> 1;
			end
		end
		if (state_q == ST_SQWT && sq_done) begin
			len_q   <= sq_root;
			div_i_q <= 2'd0;
		end
		if (state_q == ST_DVGO && len_zero) begin
			tan_q[div_i_q] <= '0;
			div_i_q        <= div_i_q + 2'd1;
		end
		if (state_q == ST_DVWT && dv_done) begin
			tan_q[div_i_q] <= tan_v;
			div_i_q        <= div_i_q + 2'd1;
		end
		if (emit_ld) begin
			res_corner_q <= corner_q;
			res_tan_q    <= tan_q;
			res_hand_q   <= d_neg_q;
			res_last_q   <= (corner_q == LAST_CORNER);
			corner_q     <= corner_q + 2'd1;
			op_q         <= OP_DT_FIRST;
		end
	end

	assign res.valid               = res_v_q;
	assign res.corner              = res_corner_q;
	assign res.tan_x               = res_tan_q[0];
	assign res.tan_y               = res_tan_q[1];
	assign res.tan_z               = res_tan_q[2];
	assign res.handedness_negative = res_hand_q;
	assign res.last_of_triangle    = res_last_q;

endmodule

// ----- rtl/tfu_chk.sv -----
// Port-level checker for the tangent frame unit, bound to the top level.
// Depends on triangle_tangent_frame_unit_defines.svh and triangle_tangent_frame_unit.
`timescale 1ns / 1ps
`include "triangle_tangent_frame_unit_defines.svh"
module tfu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        vtx_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_corner,
	input logic [15:0] res_tan_x,
	input logic        res_last
);

	`TFU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_corner) && $stable(res_tan_x), "stalled result item changed")
	`TFU_ASSERT_NOW(a_last_corner, res_valid, res_last == (res_corner == 2'd2), "last flag does not match corner")
	`TFU_ASSERT_NOW(a_busy_mid, res_valid && !res_last, !vtx_ready, "vertex taken while triangle results pending")

endmodule

bind triangle_tangent_frame_unit tfu_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.vtx_ready(vtx.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_corner(res.corner),
	.res_tan_x(res.tan_x),
	.res_last(res.last_of_triangle)
);

// ----- test/tb.sv -----
// Testbench for triangle_tangent_frame_unit: streams vertices and checks every tangent item
// against an in-bench fixed-point predictor. Depends on tfu_pkg, tfu_ifs and the unit RTL.
`timescale 1ns / 1ps
module tb;
	import tfu_pkg::*;

	typedef struct packed {
		logic        ms;
		logic [31:0] px, py, pz, tu, tv;
		logic [15:0] nx, ny, nz;
	} vertex_t;

	typedef struct packed {
		logic [1:0]  corner;
		logic [15:0] tx, ty, tz;
		logic        hneg;
		logic        last;
	} tangent_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	tfu_vtx_if vtx();
	tfu_res_if res();

	triangle_tangent_frame_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.vtx(vtx.sink), .res(res.source)
	);

	always #2 clk = ~clk;

	vertex_t  vertex_queue[$];
	tangent_t tangent_expect[$];
	int       fail_count = 0;
	int       tangents_seen = 0;
	bit       quiet = 0;
	bit       vtx_taken = 0;

	// predictor state
	longint   held_pos[6];
	longint   held_tex[4];
	longint   held_nrm[6];
	int       tri_phase = 0;
	bit       gen_en = 1;

	function automatic logic signed [127:0] wide(input longint v);
		return v;
	endfunction

	function automatic void shrink(input logic signed [127:0] v[3], input int bits,
		output longint r[3]);
		logic signed [127:0] mag[3];
		logic [127:0] m;
		int len, s;
		len = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			for (int b = 0; b < 128; b++)
				if (mag[i][b] && b + 1 > len) len = b + 1;
		end
		s = len > bits ? len - bits : 0;
		for (int i = 0; i < 3; i++) begin
			m = mag[i] >> s;
			r[i] = v[i] < 0 ? -longint'(m[63:0]) : longint'(m[63:0]);
		end
	endfunction

	function automatic void predict_tangents(input vertex_t it);
		longint p[3], tc[2], n[3], e0[3], e1[3], tr[3], br[3], tn[3], nk[3];
		longint du0, dv0, du1, dv1, cx, cy, cz, d;
		logic signed [127:0] tw[3], bw[3];
		longint unsigned ss, len, cand, m, q;
		tangent_t t;
		p[0] = longint'($signed(it.px));
		p[1] = longint'($signed(it.py));
		p[2] = longint'($signed(it.pz));
		tc[0] = longint'($signed(it.tu));
		tc[1] = longint'($signed(it.tv));
		n[0] = longint'($signed(it.nx));
		n[1] = longint'($signed(it.ny));
		n[2] = longint'($signed(it.nz));
		if (it.ms) tri_phase = 0;
		if (tri_phase < 2) begin
			for (int i = 0; i < 3; i++) begin
				held_pos[tri_phase*3+i] = p[i];
				held_nrm[tri_phase*3+i] = n[i];
			end
			held_tex[tri_phase*2] = tc[0];
			held_tex[tri_phase*2+1] = tc[1];
			tri_phase++;
			return;
		end
		tri_phase = 0;
		if (!gen_en) return;
		for (int i = 0; i < 3; i++) begin
			e0[i] = held_pos[3+i] - held_pos[i];
			e1[i] = p[i] - held_pos[i];
		end
		du0 = held_tex[2] - held_tex[0];
		dv0 = held_tex[3] - held_tex[1];
		du1 = tc[0] - held_tex[0];
		dv1 = tc[1] - held_tex[1];
		for (int i = 0; i < 3; i++) begin
			tw[i] = wide(e0[i]) * wide(dv1) - wide(e1[i]) * wide(dv0);
			bw[i] = wide(e1[i]) * wide(du0) - wide(e0[i]) * wide(du1);
		end
		shrink(tw, 30, tr);
		shrink(bw, 20, br);
		ss = 0;
		for (int i = 0; i < 3; i++) ss += longint'(tr[i] * tr[i]);
		len = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = len | (64'd1 << b);
			if (cand * cand <= ss) len = cand;
		end
		for (int i = 0; i < 3; i++) begin
			if (len == 0) begin
				tn[i] = 0;
			end else begin
				m = tr[i] < 0 ? -tr[i] : tr[i];
				q = (m * 65536 + len) / (2 * len);
				if (tr[i] < 0) tn[i] = q > 32768 ? -32768 : -longint'(q);
				else tn[i] = q > 32767 ? 32767 : longint'(q);
			end
		end
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) nk[i] = k < 2 ? held_nrm[k*3+i] : n[i];
			cx = nk[1] * tn[2] - nk[2] * tn[1];
			cy = nk[2] * tn[0] - nk[0] * tn[2];
			cz = nk[0] * tn[1] - nk[1] * tn[0];
			d = cx * br[0] + cy * br[1] + cz * br[2];
			t.corner = k[1:0];
			t.tx = tn[0][15:0];
			t.ty = tn[1][15:0];
			t.tz = tn[2][15:0];
			t.hneg = d < 0;
			t.last = k[1:0] == LAST_CORNER;
			tangent_expect.push_back(t);
		end
	endfunction

	// vertex driver
	int tx_gap = 0;
	initial begin
		vtx.valid = 1'b0;
		vtx.mesh_start = 1'b0;
		vtx.pos_x = '0; vtx.pos_y = '0; vtx.pos_z = '0;
		vtx.tex_u = '0; vtx.tex_v = '0;
		vtx.norm_x = '0; vtx.norm_y = '0; vtx.norm_z = '0;
	end

	always @(posedge clk) begin
		vtx_taken = vtx.valid && vtx.ready;
		if (vtx_taken)
			predict_tangents({vtx.mesh_start, vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.tex_u,
				vtx.tex_v, vtx.norm_x, vtx.norm_y, vtx.norm_z});
	end

	always @(negedge clk) begin
		vertex_t it;
		if (arst_n && !(vtx.valid && !vtx_taken)) begin
			if (tx_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
				tx_gap = $urandom_range(1, 5);
			if (tx_gap > 0 || vertex_queue.size() == 0) begin
				if (tx_gap > 0) tx_gap--;
				vtx.valid <= 1'b0;
			end else begin
				it = vertex_queue.pop_front();
				vtx.valid <= 1'b1;
				vtx.mesh_start <= it.ms;
				vtx.pos_x <= it.px; vtx.pos_y <= it.py; vtx.pos_z <= it.pz;
				vtx.tex_u <= it.tu; vtx.tex_v <= it.tv;
				vtx.norm_x <= it.nx; vtx.norm_y <= it.ny; vtx.norm_z <= it.nz;
			end
		end
	end

	// result side
	int  rx_gap = 0;
	int  rx_hold = 0;
	bit  rx_hold_done = 0;
	initial res.ready = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold > 0) begin
				rx_hold--;
				res.ready <= 1'b0;
			end else if (!rx_hold_done && tangents_seen >= 20) begin
				rx_hold_done = 1;
				rx_hold = 600;
				res.ready <= 1'b0;
			end else begin
				if (rx_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
					rx_gap = $urandom_range(1, 5);
				if (rx_gap > 0) begin
					rx_gap--;
					res.ready <= 1'b0;
				end else begin
					res.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		tangent_t e;
		if (res.valid && res.ready) begin
			tangents_seen++;
			if (tangent_expect.size() == 0) begin
				$error("unexpected tangent item, corner %0d", res.corner);
				fail_count++;
			end else begin
				e = tangent_expect.pop_front();
				if (res.corner !== e.corner) begin
					$error("corner exp %0d got %0d", e.corner, res.corner); fail_count++;
				end
				if (res.tan_x !== e.tx) begin
					$error("tan_x exp %0h got %0h", e.tx, res.tan_x); fail_count++;
				end
				if (res.tan_y !== e.ty) begin
					$error("tan_y exp %0h got %0h", e.ty, res.tan_y); fail_count++;
				end
				if (res.tan_z !== e.tz) begin
					$error("tan_z exp %0h got %0h", e.tz, res.tan_z); fail_count++;
				end
				if (res.handedness_negative !== e.hneg) begin
					$error("handedness_negative exp %0d got %0d", e.hneg,
						res.handedness_negative);
					fail_count++;
				end
				if (res.last_of_triangle !== e.last) begin
					$error("last_of_triangle exp %0d got %0d", e.last, res.last_of_triangle);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	function automatic vertex_t mk(input logic ms, input logic [31:0] px, py, pz, tu, tv,
		input logic [15:0] nx, ny, nz);
		return {ms, px, py, pz, tu, tv, nx, ny, nz};
	endfunction

	function automatic vertex_t rnd_vertex(input logic ms);
		vertex_t it;
		bit full;
		full = $urandom_range(0, 3) == 0;
		it.ms = ms;
		it.px = full ? $urandom : 32'($urandom_range(0, 400000)) - 32'd200000;
		it.py = full ? $urandom : 32'($urandom_range(0, 400000)) - 32'd200000;
		it.pz = full ? $urandom : 32'($urandom_range(0, 400000)) - 32'd200000;
		it.tu = full ? $urandom : 32'($urandom_range(0, 200000)) - 32'd100000;
		it.tv = full ? $urandom : 32'($urandom_range(0, 200000)) - 32'd100000;
		it.nx = full ? 16'($urandom) : 16'($urandom_range(0, 32768)) - 16'd16384;
		it.ny = full ? 16'($urandom) : 16'($urandom_range(0, 32768)) - 16'd16384;
		it.nz = full ? 16'($urandom) : 16'($urandom_range(0, 32768)) - 16'd16384;
		return it;
	endfunction

	task automatic drain();
		while (vertex_queue.size() != 0 || vtx.valid || tangent_expect.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_gen(input logic v);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		gen_en = v;
	endtask

	task automatic random_vertices(input int count);
		int n;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) begin
				vertex_queue.push_back(rnd_vertex($urandom_range(0, 1)));
				n++;
			end else begin
				vertex_queue.push_back(rnd_vertex($urandom_range(0, 3) == 0));
				vertex_queue.push_back(rnd_vertex(1'b0));
				vertex_queue.push_back(rnd_vertex(1'b0));
				n += 3;
			end
		end
	endtask

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] MINC = 32'h8000_0000;
	localparam logic [31:0] MAXC = 32'h7fff_ffff;
	localparam logic [15:0] NZ = 16'h4000;

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_gen(1'b1);
		// basic frame
		vertex_queue.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, NZ));
		vertex_queue.push_back(mk(0, ONE, 0, 0, ONE, 0, 0, 0, NZ));
		vertex_queue.push_back(mk(0, 0, ONE, 0, 0, ONE, 0, 0, NZ));
		// mirrored texcoords
		vertex_queue.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, NZ));
		vertex_queue.push_back(mk(0, ONE, 0, 0, -ONE, 0, 0, 0, NZ));
		vertex_queue.push_back(mk(0, 0, ONE, 0, 0, ONE, 0, 0, NZ));
		// field extremes
		vertex_queue.push_back(mk(0, MINC, MINC, MAXC, MINC, MAXC, 16'h8000, 16'h7fff, 16'h8000));
		vertex_queue.push_back(mk(0, MAXC, MAXC, MINC, MAXC, MINC, 16'h7fff, 16'h8000, 16'h7fff));
		vertex_queue.push_back(mk(0, MINC, MAXC, MINC, MAXC, MAXC, 16'hffff, 16'h8000, 16'h7fff));
		// degenerate texcoords give a zero tangent
		vertex_queue.push_back(mk(0, 0, 0, 0, ONE, ONE, 0, 0, NZ));
		vertex_queue.push_back(mk(0, ONE, 0, 0, ONE, ONE, 0, 0, NZ));
		vertex_queue.push_back(mk(0, 0, ONE, 0, ONE, ONE, 0, 0, NZ));
		// zero normals
		vertex_queue.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
		vertex_queue.push_back(mk(0, ONE, 0, 0, ONE, 0, 0, 0, 0));
		vertex_queue.push_back(mk(0, 0, ONE, 0, 0, ONE, 0, 0, 0));
		// one then two leftover vertices before a new mesh
		vertex_queue.push_back(mk(0, ONE, ONE, ONE, ONE, ONE, NZ, 0, 0));
		vertex_queue.push_back(mk(1, 0, 0, 0, 0, 0, 0, NZ, 0));
		vertex_queue.push_back(mk(0, 0, 0, ONE, ONE, 0, 0, NZ, 0));
		vertex_queue.push_back(mk(0, ONE, 0, 0, 0, ONE, 0, NZ, 0));
		vertex_queue.push_back(mk(1, ONE, ONE, ONE, ONE, ONE, NZ, 0, 0));
		vertex_queue.push_back(mk(0, 0, ONE, ONE, 0, ONE, NZ, 0, 0));
		vertex_queue.push_back(mk(1, 0, 0, 0, 0, 0, NZ, 0, 0));
		vertex_queue.push_back(mk(0, 0, ONE, 0, ONE, 0, NZ, 0, 0));
		vertex_queue.push_back(mk(0, 0, 0, ONE, 0, ONE, NZ, 0, 0));
		drain();
		write_gen(1'b0);
		random_vertices(24);
		drain();
		write_gen(1'b1);
		random_vertices(190);
		drain();
		write_gen(1'b0);
		random_vertices(30);
		drain();
		write_gen(1'b1);
		random_vertices(110);
		drain();
		quiet = 1;
		vertex_queue.push_back(rnd_vertex(1'b1));
		random_vertices(30);
		drain();
		if (fail_count == 0 && tangent_expect.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
